FILE: hdl/ttl_pkg.sv
// Package for the text token lexer: transaction payload types, lexer mode
// and result kind codes, configuration register indexes and reset values.
// No dependencies.
`default_nettype none

package ttl_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] REG_COMMENT_A = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_COMMENT_B = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_QUOTE     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_ESCAPE    = CfgIdxW'(3);

  localparam logic [7:0] RST_COMMENT_A = 8'h2A;
  localparam logic [7:0] RST_COMMENT_B = 8'h23;
  localparam logic [7:0] RST_QUOTE     = 8'h22;
  localparam logic [7:0] RST_ESCAPE    = 8'h5C;

  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_HT = 8'h09;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_PLAIN   = 3'd2,
    MODE_QUOTED  = 3'd3,
    MODE_ESCAPED = 3'd4
  } ttl_mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_TOKEN  = 2'd1,
    KIND_STREAM = 2'd2
  } ttl_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } ttl_in_t;

  typedef struct packed {
    ttl_kind_e  kind;
    logic [7:0] token_byte;
    logic       was_quoted;
    logic       last;
  } ttl_out_t;

  typedef struct packed {
    logic [7:0] comment_char_a;
    logic [7:0] comment_char_b;
    logic [7:0] quote_char;
    logic [7:0] escape_char;
  } ttl_cfg_t;

  // Results produced by one input item: a count of zero to two and the slots.
  typedef struct packed {
    logic [1:0] count;
    ttl_out_t   res0;
    ttl_out_t   res1;
  } ttl_step_t;

  function automatic ttl_out_t ttl_make(ttl_kind_e kind, logic [7:0] data, logic quoted);
    ttl_out_t r;
    r.kind       = kind;
    r.token_byte = data;
    r.was_quoted = quoted;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/text_token_lexer_core.sv
// Top level of the text token lexer: input register, configuration
// registers, lexer mode register, step logic and result holder.
// Depends on ttl_pkg, ttl_step and ttl_out_buf.
//
// Usage: text bytes arrive on the input channel (in_valid_i/in_ready_o),
// one transaction per byte, or one transaction with end_of_input set to
// close a stream. The output channel (out_valid_o/out_ready_i) carries
// token bytes, token-end marks and a stream-end mark; the last result of
// each input item has its last flag set. Items that yield no result, such
// as whitespace or comment text, produce no output transaction.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes the comment,
// quote and escape characters by index; it is always ready and is meant
// to be used while no item is in flight. Indexes beyond the list are ignored.
// The first result of an item passes the input register, then the result
// holder. One input item is taken per cycle while the receiver is ready;
// only an end of input that closes an open token yields two results and
// then holds the input, set by the single output port of the two-slot holder.
// Reset clears the mode to idle between tokens, loads the default
// characters and empties both the input register and the result holder.
// When the receiver stalls, results wait in the holder, the input register
// then fills and in_ready_o drops until results drain.
`default_nettype none

module text_token_lexer_core
  import ttl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ttl_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ttl_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  ttl_cfg_t  cfg_q;
  ttl_mode_e mode_q, mode_d;
  logic      in_valid_q;
  ttl_in_t   in_data_q;
  ttl_step_t step;
  logic      can_load;
  logic      proc_fire;

  assign cfg_ready_o = 1'b1;

  // Configuration registers, written by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comment_char_a <= RST_COMMENT_A;
      cfg_q.comment_char_b <= RST_COMMENT_B;
      cfg_q.quote_char     <= RST_QUOTE;
      cfg_q.escape_char    <= RST_ESCAPE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COMMENT_A: cfg_q.comment_char_a <= cfg_data_i;
        REG_COMMENT_B: cfg_q.comment_char_b <= cfg_data_i;
        REG_QUOTE:     cfg_q.quote_char     <= cfg_data_i;
        REG_ESCAPE:    cfg_q.escape_char    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The registered item is processed once the holder can take its results;
  // an item with no results never waits.
  assign proc_fire  = in_valid_q && ((step.count == 2'd0) || can_load);
  assign in_ready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  ttl_step u_step (
    .mode_i (mode_q),
    .cfg_i  (cfg_q),
    .item_i (in_data_q),
    .step_o (step),
    .mode_o (mode_d)
  );

  // The mode advances only when the item's results have been committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (proc_fire) begin
      mode_q <= mode_d;
    end
  end

  ttl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (proc_fire),
    .step_i      (step),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hdl/ttl_step.sv
// Combinational lexer step: classifies one input item against the current
// mode and configuration and gives the results and the next mode. Uses ttl_pkg.
`default_nettype none

module ttl_step
  import ttl_pkg::*;
(
  input  ttl_mode_e mode_i,
  input  ttl_cfg_t  cfg_i,
  input  ttl_in_t   item_i,
  output ttl_step_t step_o,
  output ttl_mode_e mode_o
);

  logic [7:0] c;
  logic       is_space;
  logic       is_comment;
  logic       is_eol;

  assign c          = item_i.data_byte;
  assign is_eol     = (c == CHAR_LF) || (c == CHAR_CR);
  assign is_space   = is_eol || (c == CHAR_SP) || (c == CHAR_HT) ||
                      (c == CHAR_VT) || (c == CHAR_FF);
  assign is_comment = (c == cfg_i.comment_char_a) || (c == cfg_i.comment_char_b);

  always_comb begin
    step_o = '0;
    mode_o = mode_i;
    if (item_i.end_of_input) begin
      mode_o = MODE_IDLE;
      case (mode_i)
        MODE_PLAIN: begin
          step_o.count = 2'd2;
          step_o.res0  = ttl_make(KIND_TOKEN, 8'h00, 1'b0);
          step_o.res1  = ttl_make(KIND_STREAM, 8'h00, 1'b0);
        end
        MODE_QUOTED, MODE_ESCAPED: begin
          step_o.count = 2'd2;
          step_o.res0  = ttl_make(KIND_TOKEN, 8'h00, 1'b1);
          step_o.res1  = ttl_make(KIND_STREAM, 8'h00, 1'b0);
        end
        default: begin
          step_o.count = 2'd1;
          step_o.res0  = ttl_make(KIND_STREAM, 8'h00, 1'b0);
        end
      endcase
    end else begin
      case (mode_i)
        MODE_COMMENT: begin
          if (is_eol) begin
            mode_o = MODE_IDLE;
          end
        end
        MODE_PLAIN: begin
          step_o.count = 2'd1;
          if (is_space) begin
            step_o.res0 = ttl_make(KIND_TOKEN, 8'h00, 1'b0);
            mode_o      = MODE_IDLE;
          end else if (is_comment) begin
            step_o.res0 = ttl_make(KIND_TOKEN, 8'h00, 1'b0);
            mode_o      = MODE_COMMENT;
          end else begin
            step_o.res0 = ttl_make(KIND_BYTE, c, 1'b0);
          end
        end
        MODE_QUOTED: begin
          if (c == cfg_i.quote_char) begin
            step_o.count = 2'd1;
            step_o.res0  = ttl_make(KIND_TOKEN, 8'h00, 1'b1);
            mode_o       = MODE_IDLE;
          end else if (c == cfg_i.escape_char) begin
            mode_o = MODE_ESCAPED;
          end else begin
            step_o.count = 2'd1;
            step_o.res0  = ttl_make(KIND_BYTE, c, 1'b1);
          end
        end
        MODE_ESCAPED: begin
          step_o.count = 2'd1;
          step_o.res0  = ttl_make(KIND_BYTE, c, 1'b1);
          mode_o       = MODE_QUOTED;
        end
        default: begin
          // Idle, and any code that cannot arise, behaves as idle.
          mode_o = MODE_IDLE;
          if (is_space) begin
            mode_o = MODE_IDLE;
          end else if (is_comment) begin
            mode_o = MODE_COMMENT;
          end else if (c == cfg_i.quote_char) begin
            mode_o = MODE_QUOTED;
          end else begin
            step_o.count = 2'd1;
            step_o.res0  = ttl_make(KIND_BYTE, c, 1'b0);
            mode_o       = MODE_PLAIN;
          end
        end
      endcase
    end
    step_o.res0.last = (step_o.count == 2'd1);
    step_o.res1.last = (step_o.count == 2'd2);
  end

endmodule

`default_nettype wire

FILE: hdl/ttl_out_buf.sv
// Two-slot result holder: takes the zero to two results of one item and
// presents them one per transaction on the output channel. Uses ttl_pkg.
`default_nettype none

module ttl_out_buf
  import ttl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  ttl_step_t step_i,
  output logic      can_load_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ttl_out_t  out_data_o
);

  logic [1:0] cnt_q, cnt_d;
  ttl_out_t   slot0_q, slot1_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign pop         = out_valid_o && out_ready_i;
  // The holder is free for a new item once its last result leaves.
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i && can_load_o) begin
      cnt_d = step_i.count;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      slot0_q <= step_i.res0;
      slot1_q <= step_i.res1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for text_token_lexer_core: directed and random text
// streams under several character settings, checked against a built-in lexer.
// Depends on ttl_pkg and the text_token_lexer_core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ttl_pkg::*;

  localparam int ClkHalf = 5;
  // Random items per character setting; six settings give 1830 items.
  localparam int ItemsPerSetting = 305;
  localparam int SettingCount = 6;
  // Cycles to wait once no result is outstanding: covers an item that yields
  // no result while it still sits in the input register.
  localparam int SettleCycles = 8;
  localparam int MaxPrinted = 50;
  // Number of implemented registers; indexes from here up are ignored.
  localparam int RegCount = 4;
  localparam logic [CfgIdxW-1:0] REG_NONE = '1;

  // Receiver behaviors, each held for a random span of cycles.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PERIODIC
  } ready_style_e;

  // Tracks the lexer mode and the character setting, and holds the results
  // that the accepted bytes must produce, oldest first.
  class lexer_tracker;
    ttl_cfg_t  cfg;
    ttl_mode_e mode;
    ttl_out_t  lexer_results_q[$];

    function new();
      cfg.comment_char_a = RST_COMMENT_A;
      cfg.comment_char_b = RST_COMMENT_B;
      cfg.quote_char     = RST_QUOTE;
      cfg.escape_char    = RST_ESCAPE;
      mode = MODE_IDLE;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [7:0] value);
      case (idx)
        REG_COMMENT_A: cfg.comment_char_a = value;
        REG_COMMENT_B: cfg.comment_char_b = value;
        REG_QUOTE:     cfg.quote_char     = value;
        REG_ESCAPE:    cfg.escape_char    = value;
        default: ;
      endcase
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CHAR_SP || c == CHAR_HT || c == CHAR_LF ||
             c == CHAR_CR || c == CHAR_VT || c == CHAR_FF;
    endfunction

    function bit is_comment(logic [7:0] c);
      return c == cfg.comment_char_a || c == cfg.comment_char_b;
    endfunction

    function void add_result(ttl_kind_e kind, logic [7:0] data, logic quoted);
      ttl_out_t r;
      r.kind       = kind;
      r.token_byte = data;
      r.was_quoted = quoted;
      r.last       = 1'b0;
      lexer_results_q.push_back(r);
    endfunction

    // Notes one accepted input transaction and queues the results it causes.
    function void note_item(ttl_in_t item);
      logic [7:0] c;
      int         before_n;
      ttl_out_t   r;
      c = item.data_byte;
      before_n = lexer_results_q.size();
      if (item.end_of_input) begin
        if (mode == MODE_PLAIN) begin
          add_result(KIND_TOKEN, 8'h00, 1'b0);
        end else if (mode == MODE_QUOTED || mode == MODE_ESCAPED) begin
          add_result(KIND_TOKEN, 8'h00, 1'b1);
        end
        add_result(KIND_STREAM, 8'h00, 1'b0);
        mode = MODE_IDLE;
      end else begin
        case (mode)
          MODE_COMMENT: begin
            if (c == CHAR_LF || c == CHAR_CR) mode = MODE_IDLE;
          end
          MODE_PLAIN: begin
            if (is_blank(c)) begin
              add_result(KIND_TOKEN, 8'h00, 1'b0);
              mode = MODE_IDLE;
            end else if (is_comment(c)) begin
              add_result(KIND_TOKEN, 8'h00, 1'b0);
              mode = MODE_COMMENT;
            end else begin
              add_result(KIND_BYTE, c, 1'b0);
            end
          end
          MODE_QUOTED: begin
            // The closing quote wins over the escape when both are equal.
            if (c == cfg.quote_char) begin
              add_result(KIND_TOKEN, 8'h00, 1'b1);
              mode = MODE_IDLE;
            end else if (c == cfg.escape_char) begin
              mode = MODE_ESCAPED;
            end else begin
              add_result(KIND_BYTE, c, 1'b1);
            end
          end
          MODE_ESCAPED: begin
            add_result(KIND_BYTE, c, 1'b1);
            mode = MODE_QUOTED;
          end
          default: begin
            if (is_blank(c)) begin
              mode = MODE_IDLE;
            end else if (is_comment(c)) begin
              mode = MODE_COMMENT;
            end else if (c == cfg.quote_char) begin
              mode = MODE_QUOTED;
            end else begin
              add_result(KIND_BYTE, c, 1'b0);
              mode = MODE_PLAIN;
            end
          end
        endcase
      end
      if (lexer_results_q.size() > before_n) begin
        r = lexer_results_q.pop_back();
        r.last = 1'b1;
        lexer_results_q.push_back(r);
      end
    endfunction

    // Compares one output transaction with the oldest queued result. Returns
    // an empty string on a match, otherwise a description of the mismatch.
    function string check_result(ttl_out_t got);
      ttl_out_t want;
      string    diffs;
      if (lexer_results_q.size() == 0) begin
        return $sformatf("result with none queued: kind=%0d byte=%02h quoted=%0b last=%0b",
                         got.kind, got.token_byte, got.was_quoted, got.last);
      end
      want = lexer_results_q.pop_front();
      diffs = "";
      if (got.kind !== want.kind) begin
        diffs = {diffs, $sformatf(" kind got %0d want %0d", got.kind, want.kind)};
      end
      if (got.token_byte !== want.token_byte) begin
        diffs = {diffs, $sformatf(" token_byte got %02h want %02h",
                                  got.token_byte, want.token_byte)};
      end
      if (got.was_quoted !== want.was_quoted) begin
        diffs = {diffs, $sformatf(" was_quoted got %0b want %0b",
                                  got.was_quoted, want.was_quoted)};
      end
      if (got.last !== want.last) begin
        diffs = {diffs, $sformatf(" last got %0b want %0b", got.last, want.last)};
      end
      if (diffs == "") return "";
      return {"result mismatch:", diffs};
    endfunction

    function int pending();
      return lexer_results_q.size();
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  ttl_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  ttl_out_t           out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0]         cfg_data_i  = '0;

  lexer_tracker tracker;
  int           error_count = 0;
  // Transactions left in the current sender burst.
  int           burst_left  = 0;
  ready_style_e ready_style = READY_ALWAYS;
  int unsigned  ready_span  = 0;

  text_token_lexer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("[%0t] ERROR: %s", $time, what);
    end
  endtask

  // The receiver switches between behaviors at the end of each random span:
  // always ready, mostly ready, rarely ready, and a fixed pattern of
  // one ready cycle in four. The always-ready spans give stall-free stretches.
  always @(posedge clk_i) begin
    if (ready_span == 0) begin
      ready_style <= ready_style_e'($urandom_range(0, 3));
      ready_span  <= $urandom_range(40, 300);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_style)
      READY_ALWAYS:  out_ready_i <= 1'b1;
      READY_MOSTLY:  out_ready_i <= ($urandom_range(0, 9) < 7);
      READY_RARELY:  out_ready_i <= ($urandom_range(0, 9) < 2);
      default:       out_ready_i <= (ready_span[1:0] == 2'b00);
    endcase
  end

  // Output monitor: every output transaction is checked against the oldest
  // queued result. Values are read right after the edge, so they are the ones
  // that the block saw at the edge.
  always @(posedge clk_i) begin : result_monitor
    string what;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      what = tracker.check_result(out_data_o);
      if (what != "") report_mismatch(what);
    end
  end

  // Sends one byte or end-of-input transaction. The sender runs in bursts of
  // random length; between bursts valid drops for a random gap, and about a
  // quarter of the bursts follow the previous one without any gap.
  task automatic send_item(input ttl_in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_item(item);
  endtask

  // Writes one register; valid drops afterward and is seen low by the block
  // before the task returns, so that the next write starts on a fresh edge.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops the sender and waits until every queued result has been seen, then
  // lets the block settle so that no byte without results is still in flight.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic ttl_in_t text_byte(input logic [7:0] c);
    ttl_in_t it;
    it.data_byte    = c;
    it.end_of_input = 1'b0;
    return it;
  endfunction

  // End of input; the data byte is don't-care and is randomized.
  function automatic ttl_in_t stream_end();
    ttl_in_t it;
    it.data_byte    = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    return it;
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 5))
      0:       return CHAR_SP;
      1:       return CHAR_HT;
      2:       return CHAR_LF;
      3:       return CHAR_CR;
      4:       return CHAR_VT;
      default: return CHAR_FF;
    endcase
  endfunction

  // Random item weighted toward the bytes that steer the lexer under the
  // current setting, so tokens, comments, quotes and escapes all occur often.
  // Streams end on average every thirty-odd items.
  function automatic ttl_in_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)  return stream_end();
    if (pick < 20) return text_byte(random_blank());
    if (pick < 25) return text_byte(tracker.cfg.comment_char_a);
    if (pick < 30) return text_byte(tracker.cfg.comment_char_b);
    if (pick < 42) return text_byte(tracker.cfg.quote_char);
    if (pick < 50) return text_byte(tracker.cfg.escape_char);
    if (pick < 75) return text_byte(8'($urandom_range(8'h61, 8'h7A)));
    return text_byte(8'($urandom_range(0, 255)));
  endfunction

  // Short directed stream under the reset characters: byte extremes, a quote
  // inside an unquoted token, every whitespace byte, both comment characters
  // (one ending a token), escaped quote, a token right after a closing quote,
  // an empty quoted token, and end of input with a pending escape, in an
  // unquoted token, between tokens and inside a comment.
  task automatic run_directed();
    ttl_in_t script[$];
    script = '{
      text_byte(8'h00), text_byte(8'hFF), text_byte(RST_QUOTE), text_byte(CHAR_SP),
      text_byte(8'h61), text_byte(RST_COMMENT_A), text_byte(8'h7A), text_byte(CHAR_LF),
      text_byte(RST_COMMENT_B), text_byte(CHAR_CR), text_byte(CHAR_HT),
      text_byte(RST_QUOTE), text_byte(RST_ESCAPE), text_byte(RST_QUOTE),
      text_byte(RST_QUOTE), text_byte(8'h6B), text_byte(CHAR_VT),
      text_byte(RST_QUOTE), text_byte(RST_QUOTE), text_byte(CHAR_FF),
      text_byte(RST_QUOTE), text_byte(RST_ESCAPE), stream_end(),
      text_byte(8'h62), stream_end(), stream_end(),
      text_byte(RST_COMMENT_B), stream_end()
    };
    foreach (script[i]) send_item(script[i]);
  endtask

  // Character settings after the reset one. The first three are fixed
  // extremes: byte values 0 and 255, an escape equal to the quote, a comment
  // character that is also whitespace, and a comment character equal to the
  // quote. The last two are drawn at random over the full byte range.
  function automatic ttl_cfg_t pick_setting(input int idx);
    ttl_cfg_t s;
    case (idx)
      1: s = '{comment_char_a: 8'h00, comment_char_b: 8'hFF,
               quote_char: 8'h7F, escape_char: 8'h80};
      2: s = '{comment_char_a: 8'hFF, comment_char_b: 8'h00,
               quote_char: 8'h80, escape_char: 8'h80};
      3: s = '{comment_char_a: CHAR_SP, comment_char_b: 8'h27,
               quote_char: 8'h27, escape_char: CHAR_LF};
      default: begin
        s.comment_char_a = 8'($urandom_range(0, 255));
        s.comment_char_b = 8'($urandom_range(0, 255));
        s.quote_char     = 8'($urandom_range(0, 255));
        s.escape_char    = 8'($urandom_range(0, 255));
      end
    endcase
    return s;
  endfunction

  initial begin : stimulus
    ttl_cfg_t setting;
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int s = 0; s < SettingCount; s++) begin
      if (s == 0) begin
        run_directed();
      end else begin
        wait_drained();
        setting = pick_setting(s);
        write_register(REG_COMMENT_A, setting.comment_char_a);
        write_register(REG_COMMENT_B, setting.comment_char_b);
        write_register(REG_QUOTE, setting.quote_char);
        write_register(REG_ESCAPE, setting.escape_char);
        // Writes to indexes past the list must leave every register as is.
        if (s == 1) begin
          write_register(REG_NONE, 8'($urandom_range(0, 255)));
        end else begin
          write_register(CfgIdxW'($urandom_range(RegCount, 254)),
                         8'($urandom_range(0, 255)));
        end
      end
      repeat (ItemsPerSetting) send_item(random_item());
    end

    wait_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin : watchdog
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
